// ===== sv/assert_macros.svh =====
// assertion macros shared by the i2c byte sequencer rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent on the same edge
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent on the following edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/i2cbs_pkg.sv =====
// shared types, primitive codes and tables of the i2c byte sequencer
// no dependencies
package i2cbs_pkg;

  localparam int DEFAULT_RESET_CLOCKS = 9;

  // primitive codes, same values as the request command field
  localparam logic [2:0] PRIM_IDLE  = 3'd0;
  localparam logic [2:0] PRIM_RESET = 3'd1;
  localparam logic [2:0] PRIM_START = 3'd2;
  localparam logic [2:0] PRIM_STOP  = 3'd3;
  localparam logic [2:0] PRIM_WRITE = 3'd4;
  localparam logic [2:0] PRIM_READ  = 3'd5;

  // sequencer state apart from the tick counter
  typedef struct packed {
    logic [2:0] prim;
    logic [7:0] shift;
    logic       pend_ack;
    logic       scl;
    logic       sda;
    logic       den;
    logic       nack;
    logic [7:0] rbyte;
  } seq_state_t;

  // one result per tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       nack_seen;
  } seq_res_t;

  // tick modulo three for the read bit phases
  localparam logic [1:0] MOD3_TAB [32] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
  };

endpackage

// ===== sv/i2cbs_req_if.sv =====
// request channel of the i2c byte sequencer: one bus tick per request
// depends on nothing but plain logic types
interface i2cbs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic       ack_level;
  logic       sda_in;

  modport source (output valid, command, data_byte, ack_level, sda_in, input ready);
  modport sink   (input valid, command, data_byte, ack_level, sda_in, output ready);
endinterface

// ===== sv/i2cbs_rsp_if.sv =====
// result channel of the i2c byte sequencer: line levels and status per tick
// depends on nothing but plain logic types
interface i2cbs_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;
  logic       nack_seen;

  modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                  read_value, nack_seen, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                  read_value, nack_seen, output ready);
endinterface

// ===== sv/i2c_master_byte_sequencer_core.sv =====
// top level of the i2c master byte sequencer: request register, tick logic, result register
// depends on i2cbs_pkg, i2cbs_req_if, i2cbs_rsp_if, i2cbs_step and assert_macros.svh
//
// usage
//   every request on req_ch is one quarter period of the bus clock and carries the
//   sampled sda level; command 1..5 starts bus reset, start, stop, write byte or read
//   byte when the sequencer is idle, and is ignored while a primitive runs
//   (codes six and seven are plain ticks)
//   every request yields exactly one result on rsp_ch with scl, sda, sda drive
//   enable, busy, a done pulse on the final tick, the last read byte and the last
//   sampled acknowledge
//   a request accepted on req_ch is registered in the request register, and its
//   result is then registered in the result register that drives rsp_ch
//   throughput: one request per cycle while rsp_ch is not held off; the tick counter
//   and shift register close a loop through the step logic
//   bus reset lasts 4*RESET_CLOCKS+4 ticks (40 by default), start and stop 4, write 37, read 29
//   reset: synchronous; clears both registers' valid flags and puts the sequencer
//   idle with scl and sda high and sda released
//   stall: while rsp_ch is held off the result stays put, at most one further request
//   is taken into the request register, and then req_ch.ready drops
`include "assert_macros.svh"

module i2c_master_byte_sequencer_core #(
  parameter int RESET_CLOCKS = i2cbs_pkg::DEFAULT_RESET_CLOCKS
) (
  input logic         clk,
  input logic         rst,
  i2cbs_req_if.sink   req_ch,
  i2cbs_rsp_if.source rsp_ch
);
  import i2cbs_pkg::*;

  // longest primitive sets the counter width
  localparam int MAX_LEN = (4 * RESET_CLOCKS + 4 > 37) ? 4 * RESET_CLOCKS + 4 : 37;
  localparam int TICK_W  = $clog2(MAX_LEN);

  // request register
  logic       req_vld;
  logic [2:0] cmd_q;
  logic [7:0] data_q;
  logic       ack_q;
  logic       sda_q;

  // sequencer state
  seq_state_t        st;
  seq_state_t        st_next;
  logic [TICK_W-1:0] tick;
  logic [TICK_W-1:0] tick_next;

  // result register
  logic     res_vld;
  seq_res_t res;
  seq_res_t res_next;

  logic adv;
  logic step;

  // the result slot frees when empty or taken this cycle
  assign adv  = !res_vld || rsp_ch.ready;
  assign step = req_vld && adv;

  assign req_ch.ready = !req_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (req_ch.ready) begin
      req_vld <= req_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) begin
      cmd_q  <= req_ch.command;
      data_q <= req_ch.data_byte;
      ack_q  <= req_ch.ack_level;
      sda_q  <= req_ch.sda_in;
    end
  end

  i2cbs_step #(
    .RESET_CLOCKS (RESET_CLOCKS),
    .TICK_W       (TICK_W)
  ) u_step (
    .st_cur    (st),
    .tick_cur  (tick),
    .command   (cmd_q),
    .data_byte (data_q),
    .ack_level (ack_q),
    .sda_in    (sda_q),
    .st_next   (st_next),
    .tick_next (tick_next),
    .res       (res_next)
  );

  // state advances exactly once per request that reaches the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prim     <= PRIM_IDLE;
      st.shift    <= '0;
      st.pend_ack <= 1'b0;
      st.scl      <= 1'b1;
      st.sda      <= 1'b1;
      st.den      <= 1'b0;
      st.nack     <= 1'b0;
      st.rbyte    <= '0;
      tick        <= '0;
    end else if (step) begin
      st   <= st_next;
      tick <= tick_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign rsp_ch.valid      = res_vld;
  assign rsp_ch.scl_level  = res.scl_level;
  assign rsp_ch.sda_level  = res.sda_level;
  assign rsp_ch.sda_enable = res.sda_enable;
  assign rsp_ch.busy_res   = res.busy_res;
  assign rsp_ch.done_res   = res.done_res;
  assign rsp_ch.read_value = res.read_value;
  assign rsp_ch.nack_seen  = res.nack_seen;

  // sequencer holds while no request moves into the result register
  `ASSERT_NEXT(a_hold_state, clk, rst, !step, $stable(st) && $stable(tick), "state moved without a request")

  // a done tick always returns the sequencer to idle
  `ASSERT_NEXT(a_done_idle, clk, rst, step && res_next.done_res, st.prim == PRIM_IDLE && tick == '0, "not idle after done")

  // counter stays inside the fixed primitives
  `ASSERT_IMPL(a_tick_range, clk, rst, st.prim == PRIM_START || st.prim == PRIM_STOP || st.prim == PRIM_WRITE || st.prim == PRIM_READ, tick < TICK_W'(37), "tick counter out of range")

  // a done result always comes with busy set
  `ASSERT_IMPL(a_done_busy, clk, rst, res_vld && res.done_res, res.busy_res, "done without busy")

endmodule

// ===== sv/i2cbs_step.sv =====
// one tick of the i2c byte sequencer: next state and line levels
// depends on i2cbs_pkg
module i2cbs_step #(
  parameter int RESET_CLOCKS = i2cbs_pkg::DEFAULT_RESET_CLOCKS,
  parameter int TICK_W = 6
) (
  input  i2cbs_pkg::seq_state_t st_cur,
  input  logic [TICK_W-1:0]     tick_cur,
  input  logic [2:0]            command,
  input  logic [7:0]            data_byte,
  input  logic                  ack_level,
  input  logic                  sda_in,
  output i2cbs_pkg::seq_state_t st_next,
  output logic [TICK_W-1:0]     tick_next,
  output i2cbs_pkg::seq_res_t   res
);
  import i2cbs_pkg::*;

  localparam logic [TICK_W-1:0] RESET_BASE = TICK_W'(4 * RESET_CLOCKS);
  localparam logic [TICK_W-1:0] RESET_LAST = TICK_W'(4 * RESET_CLOCKS + 3);

  // stop condition phases: scl low, sda low and driven, scl high, sda high
  function automatic seq_state_t stop_phase(seq_state_t s, logic [1:0] ph);
    seq_state_t r;
    r = s;
    case (ph)
      2'd0:    r.scl = 1'b0;
      2'd1:    begin
        r.sda = 1'b0;
        r.den = 1'b1;
      end
      2'd2:    r.scl = 1'b1;
      default: r.sda = 1'b1;
    endcase
    return r;
  endfunction

  seq_state_t        st;
  logic [TICK_W-1:0] t;
  logic [TICK_W-1:0] last;
  logic              busy;
  logic              done;

  always_comb begin
    st   = st_cur;
    t    = tick_cur;
    busy = 1'b0;
    done = 1'b0;
    last = '0;

    // a command starts only from idle and counts as tick zero
    if (st.prim == PRIM_IDLE && command inside {[PRIM_RESET:PRIM_READ]}) begin
      st.prim = command;
      t       = '0;
      if (command == PRIM_WRITE) st.shift    = data_byte;
      if (command == PRIM_READ)  st.pend_ack = ack_level;
    end

    if (st.prim != PRIM_IDLE) begin
      busy = 1'b1;
      case (st.prim)
        PRIM_RESET: begin
          last = RESET_LAST;
          if (t < RESET_BASE) begin
            if (t == '0) begin
              st.sda = 1'b1;
              st.den = 1'b0;
            end
            case (t[1:0])
              2'd0:    st.scl = 1'b0;
              2'd2:    st.scl = 1'b1;
              default: ;
            endcase
          end else begin
            st = stop_phase(st, t[1:0]);
          end
        end
        PRIM_START: begin
          last = TICK_W'(3);
          case (t[1:0])
            2'd1:    begin
              st.sda = 1'b1;
              st.den = 1'b1;
            end
            2'd2:    st.scl = 1'b1;
            2'd3:    st.sda = 1'b0;
            default: ;
          endcase
        end
        PRIM_STOP: begin
          last = TICK_W'(3);
          st   = stop_phase(st, t[1:0]);
        end
        PRIM_WRITE: begin
          last = TICK_W'(36);
          if (t == '0) st.den = 1'b1;
          if (t < TICK_W'(32)) begin
            case (t[1:0])
              2'd0:    st.scl = 1'b0;
              2'd1:    begin
                st.sda   = st.shift[7];
                st.shift = {st.shift[6:0], 1'b0};
              end
              2'd2:    st.scl = 1'b1;
              default: ;
            endcase
          end else if (t == TICK_W'(32)) begin
            st.scl = 1'b0;
          end else if (t == TICK_W'(33)) begin
            st.sda = 1'b1;
            st.den = 1'b0;
          end else if (t == TICK_W'(34)) begin
            st.scl = 1'b1;
          end else if (t == TICK_W'(35)) begin
            st.nack = sda_in;
          end else begin
            st.scl = 1'b0;
          end
        end
        PRIM_READ: begin
          last = TICK_W'(28);
          if (t == '0) begin
            st.den   = 1'b0;
            st.shift = '0;
          end
          if (t < TICK_W'(24)) begin
            case (MOD3_TAB[t[4:0]])
              2'd0:    st.scl = 1'b0;
              2'd1:    begin
                st.scl   = 1'b1;
                st.shift = {st.shift[6:0], sda_in};
              end
              default: ;
            endcase
          end else if (t == TICK_W'(24)) begin
            st.den = 1'b1;
            st.scl = 1'b0;
          end else if (t == TICK_W'(25)) begin
            st.sda = st.pend_ack;
          end else if (t == TICK_W'(26)) begin
            st.scl = 1'b1;
          end else if (t == TICK_W'(28)) begin
            st.scl = 1'b0;
          end
        end
        default: ;
      endcase
      done = (t == last);
      if (done && st.prim == PRIM_READ) st.rbyte = st.shift;
    end

    res.scl_level  = st.scl;
    res.sda_level  = st.sda;
    res.sda_enable = st.den;
    res.busy_res   = busy;
    res.done_res   = done;
    res.read_value = st.rbyte;
    res.nack_seen  = st.nack;

    // after the final tick: release or keep sda, back to idle; otherwise the tick counter advances
    if (busy) begin
      if (done) begin
        if (st.prim == PRIM_RESET || st.prim == PRIM_STOP) st.den = 1'b0;
        else if (st.prim == PRIM_WRITE) st.den = 1'b1;
        st.prim = PRIM_IDLE;
        t       = '0;
      end else begin
        t = t + TICK_W'(1);
      end
    end

    st_next   = st;
    tick_next = t;
  end

endmodule

// ===== dv/i2cbs_tick_checker.sv =====
// checker for the i2c byte sequencer: watches both channels, predicts every tick, compares
// depends on i2cbs_pkg, i2cbs_req_if and i2cbs_rsp_if
`timescale 1ns / 1ps

module i2cbs_tick_checker #(
  parameter int RESET_CLOCKS = i2cbs_pkg::DEFAULT_RESET_CLOCKS
) (
  input  logic  clk,
  input  logic  rst,
  i2cbs_req_if  req,
  i2cbs_rsp_if  rsp,
  output int    err_count,
  output int    outstanding
);
  import i2cbs_pkg::*;

  // predicted sequencer state
  logic [2:0] m_prim;
  logic [6:0] m_tick;
  logic [7:0] m_shift;
  logic       m_pend;
  logic       m_scl;
  logic       m_sda;
  logic       m_den;
  logic       m_nack;
  logic [7:0] m_rbyte;

  seq_res_t line_q[$];

  function automatic logic [6:0] prim_ticks(logic [2:0] p);
    case (p)
      PRIM_RESET:            return 7'(4 * RESET_CLOCKS + 4);
      PRIM_START, PRIM_STOP: return 7'd4;
      PRIM_WRITE:            return 7'd37;
      PRIM_READ:             return 7'd29;
      default:               return 7'd1;
    endcase
  endfunction

  // line moves of the four stop condition ticks
  function automatic void stop_edge(logic [1:0] s);
    case (s)
      2'd0: m_scl = 1'b0;
      2'd1: begin
        m_sda = 1'b0;
        m_den = 1'b1;
      end
      2'd2: m_scl = 1'b1;
      default: m_sda = 1'b1;
    endcase
  endfunction

  task automatic predict_tick(input logic [2:0] cmd, input logic [7:0] db, input logic ack,
                              input logic sda_s, output seq_res_t r);
    logic       busy;
    logic       done;
    logic [6:0] base;
    busy = 1'b0;
    done = 1'b0;
    base = 7'(4 * RESET_CLOCKS);

    if (m_prim == PRIM_IDLE && cmd inside {[PRIM_RESET:PRIM_READ]}) begin
      m_prim = cmd;
      m_tick = '0;
      if (cmd == PRIM_WRITE) m_shift = db;
      if (cmd == PRIM_READ) m_pend = ack;
    end

    if (m_prim != PRIM_IDLE) begin
      case (m_prim)
        PRIM_RESET: begin
          if (m_tick < base) begin
            if (m_tick == 7'd0) begin
              m_sda = 1'b1;
              m_den = 1'b0;
            end
            if (m_tick[1:0] == 2'd0) m_scl = 1'b0;
            else if (m_tick[1:0] == 2'd2) m_scl = 1'b1;
          end else begin
            stop_edge(2'(m_tick - base));
          end
        end
        PRIM_START: begin
          if (m_tick == 7'd1) begin
            m_sda = 1'b1;
            m_den = 1'b1;
          end else if (m_tick == 7'd2) begin
            m_scl = 1'b1;
          end else if (m_tick == 7'd3) begin
            m_sda = 1'b0;
          end
        end
        PRIM_STOP: stop_edge(m_tick[1:0]);
        PRIM_WRITE: begin
          if (m_tick == 7'd0) m_den = 1'b1;
          if (m_tick < 7'd32) begin
            case (m_tick[1:0])
              2'd0: m_scl = 1'b0;
              2'd1: begin
                m_sda   = m_shift[7];
                m_shift = {m_shift[6:0], 1'b0};
              end
              2'd2: m_scl = 1'b1;
              default: ;
            endcase
          end else if (m_tick == 7'd32) begin
            m_scl = 1'b0;
          end else if (m_tick == 7'd33) begin
            m_sda = 1'b1;
            m_den = 1'b0;
          end else if (m_tick == 7'd34) begin
            m_scl = 1'b1;
          end else if (m_tick == 7'd35) begin
            m_nack = sda_s;
          end else begin
            m_scl = 1'b0;
          end
        end
        PRIM_READ: begin
          if (m_tick == 7'd0) begin
            m_den   = 1'b0;
            m_shift = '0;
          end
          if (m_tick < 7'd24) begin
            if (m_tick % 3 == 0) begin
              m_scl = 1'b0;
            end else if (m_tick % 3 == 1) begin
              m_scl   = 1'b1;
              m_shift = {m_shift[6:0], sda_s};
            end
          end else if (m_tick == 7'd24) begin
            m_den = 1'b1;
            m_scl = 1'b0;
          end else if (m_tick == 7'd25) begin
            m_sda = m_pend;
          end else if (m_tick == 7'd26) begin
            m_scl = 1'b1;
          end else if (m_tick == 7'd28) begin
            m_scl = 1'b0;
          end
        end
        default: ;
      endcase
      busy = 1'b1;
      done = (m_tick + 7'd1 >= prim_ticks(m_prim));
      if (done && m_prim == PRIM_READ) m_rbyte = m_shift;
    end

    r.scl_level  = m_scl;
    r.sda_level  = m_sda;
    r.sda_enable = m_den;
    r.busy_res   = busy;
    r.done_res   = done;
    r.read_value = m_rbyte;
    r.nack_seen  = m_nack;

    if (busy) begin
      if (done) begin
        if (m_prim == PRIM_RESET || m_prim == PRIM_STOP) m_den = 1'b0;
        else if (m_prim == PRIM_WRITE) m_den = 1'b1;
        m_prim = PRIM_IDLE;
        m_tick = '0;
      end else begin
        m_tick = m_tick + 7'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    seq_res_t pred;
    seq_res_t want;
    if (rst) begin
      m_prim    = PRIM_IDLE;
      m_tick    = '0;
      m_shift   = '0;
      m_pend    = 1'b0;
      m_scl     = 1'b1;
      m_sda     = 1'b1;
      m_den     = 1'b0;
      m_nack    = 1'b0;
      m_rbyte   = '0;
      err_count = 0;
      line_q.delete();
    end else begin
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        predict_tick(req.command, req.data_byte, req.ack_level, req.sda_in, pred);
        line_q.push_back(pred);
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (line_q.size() == 0) begin
          $error("result with no request outstanding");
          err_count++;
        end else begin
          want = line_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(rsp.scl_level));
          check_field("sda_level", 8'(want.sda_level), 8'(rsp.sda_level));
          check_field("sda_enable", 8'(want.sda_enable), 8'(rsp.sda_enable));
          check_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("nack_seen", 8'(want.nack_seen), 8'(rsp.nack_seen));
        end
      end
    end
    outstanding = line_q.size();
  end

endmodule

// ===== dv/tb_i2c_master_byte_sequencer_core.sv =====
// testbench top for the i2c master byte sequencer: clock, reset, request and result traffic
// depends on i2cbs_pkg, both channel interfaces, the core and i2cbs_tick_checker
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer_core;
  import i2cbs_pkg::*;

  localparam int RST_CLOCKS   = DEFAULT_RESET_CLOCKS;
  localparam int TOTAL_ITEMS  = 800;
  localparam int CYCLE_LIMIT  = 500000;
  // request and result registers only, so a short tail is plenty
  localparam int TAIL_CYCLES  = 10;

  // spare command codes, which the core treats as plain ticks
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  logic clk;
  logic rst;
  int   err_count;
  int   outstanding;
  int   cycles = 0;
  int   sent = 0;
  int   stall_left = 0;
  bit   no_gaps = 1'b0;      // request side runs back to back
  bit   rsp_steady = 1'b0;   // result side starts no new stall

  i2cbs_req_if req_ch ();
  i2cbs_rsp_if rsp_ch ();

  i2c_master_byte_sequencer_core #(
    .RESET_CLOCKS(RST_CLOCKS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  i2cbs_tick_checker #(
    .RESET_CLOCKS(RST_CLOCKS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .err_count   (err_count),
    .outstanding (outstanding)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // idle length: mostly short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(30, 80);
  endfunction

  function automatic int req_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 99) < 65) return 0;
    return pick_gap();
  endfunction

  // ticks each primitive takes, so the stimulus can line up its bit phases
  function automatic int prim_len(logic [2:0] cmd);
    case (cmd)
      PRIM_RESET:            return 4 * RST_CLOCKS + 4;
      PRIM_START, PRIM_STOP: return 4;
      PRIM_WRITE:            return 37;
      PRIM_READ:             return 29;
      default:               return 1;
    endcase
  endfunction

  // result side back-pressure, changed at the falling edge only
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!rsp_steady && $urandom_range(0, 99) < 25) begin
      stall_left   <= pick_gap() - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // one bus tick request; valid is only dropped when a gap is wanted, so a
  // back to back request keeps it high
  task automatic send_req(input logic [2:0] cmd, input logic [7:0] db, input logic ack,
                          input logic sda_s);
    int gap;
    gap = req_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.data_byte <= db;
    req_ch.ack_level <= ack;
    req_ch.sda_in    <= sda_s;
    do @(posedge clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
    sent++;
  endtask

  // a whole primitive: the command on tick 0, then the ticks that carry it
  // rd_bits feeds the read sample ticks, ack_sda the write acknowledge tick
  // stray puts commands on busy ticks, the done tick always among them
  task automatic run_prim(input logic [2:0] cmd, input logic [7:0] db, input logic ack,
                          input logic [7:0] rd_bits, input logic ack_sda, input bit stray);
    int         n;
    logic [2:0] c;
    logic       s;
    n = prim_len(cmd);
    send_req(cmd, db, ack, 1'($urandom_range(0, 1)));
    for (int t = 1; t < n; t++) begin
      s = 1'($urandom_range(0, 1));
      if (cmd == PRIM_READ && t < 24 && t % 3 == 1) s = rd_bits[7 - t / 3];
      if (cmd == PRIM_WRITE && t == 35) s = ack_sda;
      c = PRIM_IDLE;
      if (stray && (t == n - 1 || $urandom_range(0, 3) == 0)) c = 3'($urandom_range(1, 7));
      send_req(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int goal;
    int r;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.command   = PRIM_IDLE;
    req_ch.data_byte = '0;
    req_ch.ack_level = 1'b0;
    req_ch.sda_in    = 1'b1;
    rsp_ch.ready     = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: every primitive, byte extremes, ack and nack, ignored commands
    send_req(PRIM_IDLE, 8'h00, 1'b0, 1'b1);
    run_prim(PRIM_RESET, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_prim(PRIM_START, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0);
    // all ones written, slave leaves sda high: nack
    run_prim(PRIM_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b0);
    // all zeros written, acknowledged, with commands thrown in while busy
    run_prim(PRIM_WRITE, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b1);
    run_prim(PRIM_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0, 1'b0);
    // read of all ones answered with noack, then all zeros with ack
    run_prim(PRIM_READ, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0);
    run_prim(PRIM_READ, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b1);
    run_prim(PRIM_READ, 8'h3C, 1'b0, 8'h5A, 1'b0, 1'b0);
    run_prim(PRIM_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    // spare codes while idle do nothing
    send_req(CMD_SPARE_6, 8'hFF, 1'b1, 1'b0);
    send_req(CMD_SPARE_7, 8'h00, 1'b0, 1'b1);
    run_prim(PRIM_RESET, 8'h81, 1'b1, 8'h00, 1'b0, 1'b1);

    // sender holds off until every result is back
    drain_results();

    // random part until the whole run reaches its request count: mostly whole
    // primitives with random content, some loose ticks
    goal = TOTAL_ITEMS;
    while (sent < goal) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 9) == 0) rsp_steady = ~rsp_steady;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        run_prim(3'($urandom_range(1, 5)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== i2c_master_byte_sequencer_core.f =====
+incdir+sv
sv/i2cbs_pkg.sv
sv/i2cbs_req_if.sv
sv/i2cbs_rsp_if.sv
sv/i2cbs_step.sv
sv/i2c_master_byte_sequencer_core.sv
dv/i2cbs_tick_checker.sv
dv/tb_i2c_master_byte_sequencer_core.sv
